### rtl/core/keyword_prefix_slot_hasher_defines.svh
// Assertion macros shared by the keyword prefix slot hasher modules.
`ifndef KEYWORD_PREFIX_SLOT_HASHER_DEFINES_SVH
`define KEYWORD_PREFIX_SLOT_HASHER_DEFINES_SVH

`ifndef SYNTHESIS
`define KPSH_CHECK(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("kpsh check failed");
`define KPSH_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kpsh sequence check failed");
`else
`define KPSH_CHECK(lbl, expr)
`define KPSH_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/kpsh_pkg.sv
// Package with the job type and hash constants of the keyword prefix slot hasher.
`default_nettype none
package kpsh_pkg;
    localparam int HASH_BITS    = 16;
    localparam int PREFIX_COUNT = 3;
    localparam int PREFIX_WORDS = 3;
    localparam int SLOT_W       = 16;
    localparam int WORD_W       = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int HASH_SHIFT   = WORD_W - HASH_BITS;

    localparam logic [WORD_W-1:0] HASH_MULT = 32'h4F1B_BCDC;
    localparam logic [1:0] PREFIX_LIMIT =
        (PREFIX_COUNT < PREFIX_WORDS) ? 2'(PREFIX_COUNT) : 2'(PREFIX_WORDS);
    localparam logic [7:0] UPPER_A   = 8'h41;
    localparam logic [7:0] UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_STEP = 8'h20;

    typedef struct packed {
        logic [PREFIX_WORDS-1:0][WORD_W-1:0] words;
        logic [1:0]                          count;
    } kpsh_job_t;
endpackage
`default_nettype wire

### rtl/core/kpsh_front.sv
// Front end: folds keyword bytes into the three prefix XOR words and issues jobs.
`default_nettype none
`include "keyword_prefix_slot_hasher_defines.svh"
module kpsh_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             s_tlast,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output kpsh_pkg::kpsh_job_t   job
);
    import kpsh_pkg::*;

    logic [WORD_W-1:0] xor_full_reg, xor_full_next;
    logic [WORD_W-1:0] xor_less_one_reg, xor_less_one_next;
    logic [WORD_W-1:0] xor_less_two_reg, xor_less_two_next;
    logic [1:0]        lane_reg, lane_next;
    logic [1:0]        len_reg, len_next;
    logic [7:0]        byte_low;
    logic [WORD_W-1:0] lane_word;
    logic [WORD_W-1:0] full_upd;
    logic [1:0]        len_sat;
    logic              s_fire;

    assign s_tready = job_ready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        byte_low = s_tdata;
        if (s_tdata >= UPPER_A && s_tdata <= UPPER_Z) begin
            byte_low = s_tdata + CASE_STEP;
        end
        lane_word = WORD_W'(byte_low) << {lane_reg, 3'b000};
        full_upd  = xor_full_reg ^ lane_word;
        len_sat   = (len_reg == 2'd3) ? 2'd3 : len_reg + 2'd1;

        job.words[0] = full_upd;
        job.words[1] = xor_full_reg;
        job.words[2] = xor_less_one_reg;
        job.count    = (len_sat < PREFIX_LIMIT) ? len_sat : PREFIX_LIMIT;
        job_valid    = s_fire && s_tlast;

        xor_full_next     = xor_full_reg;
        xor_less_one_next = xor_less_one_reg;
        xor_less_two_next = xor_less_two_reg;
        lane_next         = lane_reg;
        len_next          = len_reg;
        if (s_fire) begin
            if (s_tlast) begin
                xor_full_next     = '0;
                xor_less_one_next = '0;
                xor_less_two_next = '0;
                lane_next         = '0;
                len_next          = '0;
            end else begin
                xor_full_next     = full_upd;
                xor_less_one_next = xor_full_reg;
                xor_less_two_next = xor_less_one_reg;
                lane_next         = lane_reg + 2'd1;
                len_next          = len_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xor_full_reg     <= '0;
            xor_less_one_reg <= '0;
            xor_less_two_reg <= '0;
            lane_reg         <= '0;
            len_reg          <= '0;
        end else begin
            xor_full_reg     <= xor_full_next;
            xor_less_one_reg <= xor_less_one_next;
            xor_less_two_reg <= xor_less_two_next;
            lane_reg         <= lane_next;
            len_reg          <= len_next;
        end
    end

    `KPSH_CHECK(a_job_nonempty, !job_valid || job.count != 2'd0)
    `KPSH_CHECK_NEXT(a_clear_after_last, s_fire && s_tlast, lane_reg == 2'd0 && len_reg == 2'd0)
endmodule
`default_nettype wire

### rtl/core/kpsh_queue.sv
// Two-entry job queue between the front end and the hash back end.
`default_nettype none
`include "keyword_prefix_slot_hasher_defines.svh"
module kpsh_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    output logic                     in_ready,
    input  wire kpsh_pkg::kpsh_job_t in_job,
    output logic                     out_valid,
    input  wire logic                pop,
    output kpsh_pkg::kpsh_job_t      out_job
);
    import kpsh_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

    kpsh_job_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign in_ready  = (count_reg != FULL_COUNT);
    assign out_valid = (count_reg != '0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    `KPSH_CHECK(a_count_bound, count_reg <= FULL_COUNT)
    `KPSH_CHECK(a_no_push_when_full, !push || in_ready)
endmodule
`default_nettype wire

### rtl/core/kpsh_back.sv
// Back end: multiplies each prefix word by the hash constant and emits slot indices.
`default_nettype none
`include "keyword_prefix_slot_hasher_defines.svh"
module kpsh_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire kpsh_pkg::kpsh_job_t q_job,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [15:0]              m_tdata,
    output logic                     m_tlast
);
    import kpsh_pkg::*;

    logic              job_valid_reg, job_valid_next;
    kpsh_job_t         job_reg, job_next;
    logic [1:0]        k_reg, k_next;
    logic              mul_valid_reg, mul_valid_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic              mul_last_reg, mul_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              out_last_reg, out_last_next;
    logic              out_load, mul_free, issue, issue_last;
    logic [WORD_W-1:0] mul_word;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = slot_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        out_load   = !out_valid_reg || m_tready;
        mul_free   = !mul_valid_reg || out_load;
        issue      = job_valid_reg && mul_free;
        issue_last = (k_reg + 2'd1 == job_reg.count);
        q_ready    = !job_valid_reg || (issue && issue_last);
        mul_word   = job_reg.words[k_reg];

        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        k_next         = k_reg;
        if (issue) begin
            k_next = k_reg + 2'd1;
            if (issue_last) begin
                job_valid_next = 1'b0;
                k_next         = '0;
            end
        end
        if (q_ready && q_valid) begin
            job_valid_next = 1'b1;
            job_next       = q_job;
            k_next         = '0;
        end

        mul_valid_next = mul_valid_reg;
        prod_next      = prod_reg;
        mul_last_next  = mul_last_reg;
        if (mul_free) begin
            mul_valid_next = issue;
            prod_next      = mul_word * HASH_MULT;
            mul_last_next  = issue_last;
        end

        out_valid_next = out_valid_reg;
        slot_next      = slot_reg;
        out_last_next  = out_last_reg;
        if (out_load) begin
            out_valid_next = mul_valid_reg;
            slot_next      = SLOT_W'(prod_reg >> HASH_SHIFT);
            out_last_next  = mul_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            k_reg         <= '0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            k_reg         <= k_next;
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        prod_reg     <= prod_next;
        mul_last_reg <= mul_last_next;
        slot_reg     <= slot_next;
        out_last_reg <= out_last_next;
    end

    `KPSH_CHECK(a_index_in_job, !job_valid_reg || k_reg < job_reg.count)
    `KPSH_CHECK_NEXT(a_wrap_after_last, issue && issue_last, k_reg == 2'd0)
endmodule
`default_nettype wire

### rtl/core/keyword_prefix_slot_hasher.sv
// Top level of the keyword prefix slot hasher.
// The block takes one keyword byte per cycle while s_tready is high and folds it into
// three prefix XOR words; the byte marked with tlast hands a job to a two-entry queue
// and the next keyword may start in the following cycle. A back end multiplies one
// prefix word per cycle by the hash constant while the result channel accepts, so a
// keyword yields its one to three slot indices in order, the last one with tlast.
// The first index passes through the queue entry, the job register, the product
// register and the output register before it is offered on m_tvalid. Since a
// keyword never yields more indices than it has bytes, the back end keeps pace
// with the input, and s_tready falls only when the result channel holds off long
// enough to fill the back end and the queue.
`default_nettype none
module keyword_prefix_slot_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] slot_index
    output logic             m_tlast
);
    import kpsh_pkg::*;

    logic      push, push_ready, q_valid, q_ready;
    kpsh_job_t push_job, q_job;

    kpsh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (push),
        .job_ready (push_ready),
        .job       (push_job)
    );

    kpsh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (q_valid),
        .pop       (q_ready),
        .out_job   (q_job)
    );

    kpsh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_job    (q_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the keyword prefix slot hasher stream block.
`default_nettype none
module testbench;

    localparam logic [7:0]  LETTER_UPPER_A = 8'h41;
    localparam logic [7:0]  LETTER_UPPER_Z = 8'h5A;
    localparam logic [7:0]  LOWER_OFFSET   = 8'h20;
    localparam logic [31:0] SLOT_MULT      = 32'h4F1B_BCDC;
    localparam int          SLOT_BITS      = 16;
    localparam int          PREFIX_KEEP    = 3;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          HOLD_AT_BYTE   = 200;
    localparam int          DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_last;
    } key_xfer_t;

    typedef struct packed {
        logic [15:0] slot_index;
        logic        run_last;
    } slot_xfer_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] key_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [15:0] slot_index
    logic        m_tlast;

    key_xfer_t  pending_bytes[$];
    slot_xfer_t expected_slots[$];

    logic [31:0] hash_full;
    logic [31:0] hash_less_one;
    logic [31:0] hash_less_two;
    logic [1:0]  byte_lane;
    logic [1:0]  bytes_seen;

    int bytes_total;
    int bytes_taken;
    int keywords_done;
    int slots_checked;
    int error_count;
    int cycle_count;
    int hold_left;
    logic hold_started;
    logic may_idle;

    keyword_prefix_slot_hasher u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [15:0] slot_of(input logic [31:0] word);
        logic [31:0] prod;
        prod = word * SLOT_MULT;
        return 16'(prod >> (32 - SLOT_BITS));
    endfunction

    function automatic void clear_hash_state();
        hash_full     = '0;
        hash_less_one = '0;
        hash_less_two = '0;
        byte_lane     = '0;
        bytes_seen    = '0;
    endfunction

    // Folds one accepted byte into the prefix words and queues the slot
    // indices that the final byte of a keyword produces.
    function automatic void fold_key_byte(input logic [7:0] raw, input logic is_last);
        logic [7:0]  folded;
        logic [31:0] words[3];
        int          count;
        slot_xfer_t  slot;
        folded = raw;
        if (raw >= LETTER_UPPER_A && raw <= LETTER_UPPER_Z) begin
            folded = raw + LOWER_OFFSET;
        end
        hash_less_two = hash_less_one;
        hash_less_one = hash_full;
        hash_full     = hash_full ^ (32'(folded) << (8 * byte_lane));
        byte_lane     = byte_lane + 2'd1;
        if (bytes_seen < 2'd3) begin
            bytes_seen = bytes_seen + 2'd1;
        end
        if (is_last) begin
            words[0] = hash_full;
            words[1] = hash_less_one;
            words[2] = hash_less_two;
            count = (int'(bytes_seen) < PREFIX_KEEP) ? int'(bytes_seen) : PREFIX_KEEP;
            for (int k = 0; k < count; k++) begin
                slot.slot_index = slot_of(words[k]);
                slot.run_last   = (k == count - 1);
                expected_slots  = {expected_slots, slot};
            end
            clear_hash_state();
            keywords_done++;
        end
    endfunction

    task automatic queue_keyword(input logic [7:0] word_bytes[$]);
        key_xfer_t x;
        foreach (word_bytes[i]) begin
            x.key_byte    = word_bytes[i];
            x.key_last    = (i == word_bytes.size() - 1);
            pending_bytes = {pending_bytes, x};
            bytes_total++;
        end
    endtask

    function automatic logic [7:0] random_key_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            return 8'($urandom_range(8'h5A, 8'h41));
        end else if (pick < 60) begin
            return 8'($urandom_range(8'h7A, 8'h61));
        end
        return 8'($urandom_range(255, 0));
    endfunction

    assign may_idle = !(bytes_taken >= 300 && bytes_taken < 420);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d of %0d bytes taken.",
                     cycle_count, bytes_taken, bytes_total);
            $display("FAIL keyword_prefix_slot_hasher");
            $finish;
        end
    end

    // Key byte driver and input-side prediction.
    always @(posedge aclk) begin
        key_xfer_t next_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                fold_key_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (pending_bytes.size() != 0 &&
                         !(may_idle && $urandom_range(99) < 10)) begin
                next_item = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.key_byte;
                s_tlast  <= next_item.key_last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long hold-off of the result channel while key bytes keep coming.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left    <= 0;
            hold_started <= 1'b0;
        end else if (!hold_started && bytes_taken >= HOLD_AT_BYTE) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && !(may_idle && $urandom_range(99) < 10);
        end
    end

    // Slot index monitor.
    always @(posedge aclk) begin
        slot_xfer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_slots.size() == 0) begin
                $error("Unexpected slot index transfer: slot_index=%h run_last=%0b",
                       m_tdata, m_tlast);
                error_count++;
            end else begin
                want = expected_slots.pop_front();
                if (m_tdata !== want.slot_index) begin
                    $error("slot_index mismatch: expected %h, actual %h",
                           want.slot_index, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.run_last) begin
                    $error("run_last mismatch: expected %0b, actual %0b",
                           want.run_last, m_tlast);
                    error_count++;
                end
                slots_checked++;
            end
        end
    end

    initial begin
        logic [7:0] word_bytes[$];
        int         length;
        int         pick;
        int         random_bytes;
        clear_hash_state();
        bytes_total   = 0;
        bytes_taken   = 0;
        keywords_done = 0;
        slots_checked = 0;
        error_count   = 0;
        cycle_count   = 0;
        random_bytes  = 0;

        // Letter bounds, bytes just outside them, high bytes, lane wrap.
        queue_keyword({8'h41});
        queue_keyword({8'h5A, 8'h40});
        queue_keyword({8'h5B, 8'h00, 8'hFF});
        queue_keyword({8'h80, 8'h7F, 8'h61, 8'h7A, 8'h2D});
        queue_keyword({8'h4B, 8'h45, 8'h59, 8'h57, 8'h4F, 8'h52, 8'h44, 8'h53, 8'h21});

        while (random_bytes < 480) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                length = 1;
            end else if (pick < 35) begin
                length = 2;
            end else if (pick < 38) begin
                length = $urandom_range(40, 20);
            end else begin
                length = $urandom_range(12, 3);
            end
            word_bytes.delete();
            for (int i = 0; i < length; i++) begin
                word_bytes = {word_bytes, random_key_byte()};
            end
            queue_keyword(word_bytes);
            random_bytes += length;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_taken != bytes_total) begin
            @(posedge aclk);
        end
        while (expected_slots.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d key bytes in %0d keywords and checked %0d slot indices,",
                 bytes_taken, keywords_done, slots_checked);
        $display("including a %0d-cycle result hold-off that backed up the input.",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("PASS keyword_prefix_slot_hasher");
        end else begin
            $display("FAIL keyword_prefix_slot_hasher");
        end
        $finish;
    end

endmodule
`default_nettype wire
